// ===== sv/nbw_pkg.sv =====
// Shared types, register codes, constants and table helpers for the edge weight stream.
`default_nettype none
package nbw_pkg;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       start_of_frame;
  } pix_t;

  typedef struct packed {
    logic [17:0] left_weight;
    logic [17:0] upleft_weight;
    logic [17:0] up_weight;
    logic [17:0] upright_weight;
  } wgt_t;

  typedef enum logic [1:0] {
    NB_LEFT,
    NB_UPLEFT,
    NB_UP,
    NB_UPRIGHT
  } nb_e;

  typedef struct packed {
    nb_e  nb;
    logic present;
  } wtag_t;

  typedef struct packed {
    logic [23:0] cur;
    logic [23:0] left;
    logic [23:0] upleft;
    logic [23:0] up;
    logic [23:0] upright;
    logic [3:0]  present;
  } job_t;

  localparam logic [1:0]  REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0]  REG_BETA_SCALE   = 2'd1;
  localparam logic [1:0]  REG_GAMMA_WEIGHT = 2'd2;

  localparam logic [11:0] IMAGE_WIDTH_RST  = 12'd640;
  localparam logic [31:0] BETA_SCALE_RST   = 32'd0;
  localparam logic [9:0]  GAMMA_WEIGHT_RST = 10'd50;

  localparam logic [30:0] LOG2E_Q30     = 31'd1549082005;
  localparam logic [29:0] INV_SQRT2_Q30 = 30'd759250125;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bitv;
    v    = v_in;
    res  = '0;
    bitv = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Ratio between neighboring table entries, 2^(-1/2^bits) in Q30.
  function automatic logic [63:0] exp_root(input int unsigned bits);
    logic [63:0] r;
    r = 64'h2000_0000;
    for (int unsigned k = 0; k < bits; k++) begin
      r = isqrt64(r << 30);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/nbw_queue.sv =====
// Two-entry queue that carries neighbor jobs from the front to the back.
`default_nettype none
module nbw_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  nbw_pkg::job_t push_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output nbw_pkg::job_t pop_o
);
  import nbw_pkg::*;

  job_t       mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic       push;
  logic       pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_o        = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q != 2'd3)
    else $error("queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with unequal pointers");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("full queue with unequal pointers");

endmodule
`default_nettype wire

// ===== sv/nbw_front.sv =====
// Front end: raster position tracking, line store and neighbor gathering.
`default_nettype none
module nbw_front #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pix_valid_i,
  output logic          pix_ready_o,
  input  nbw_pkg::pix_t pix_i,
  input  logic [11:0]   image_width_i,
  output logic          job_valid_o,
  input  logic          job_ready_i,
  output nbw_pkg::job_t job_o
);
  import nbw_pkg::*;

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  typedef enum logic {
    ST_IDLE,
    ST_LOOK
  } state_e;

  state_e      state_q;
  logic [23:0] line_mem [MAX_WIDTH];
  logic [23:0] up_rd_q;
  logic [23:0] upright_rd_q;
  logic [23:0] cur_q;
  logic [23:0] left_q;
  logic [23:0] upleft_q;
  logic [AW-1:0] col_q;
  logic        first_q;
  logic [3:0]  present_q;

  logic [AW:0]   width_eff;
  logic [AW-1:0] col;
  logic          first;
  logic [AW:0]   col_next;
  logic          accept;
  logic [23:0]   cur;

  assign pix_ready_o = (state_q == ST_IDLE);
  assign job_valid_o = (state_q == ST_LOOK);
  assign accept      = pix_valid_i && pix_ready_o;
  assign cur         = {pix_i.red, pix_i.green, pix_i.blue};

  always_comb begin
    if (image_width_i == 12'd0) begin
      width_eff = (AW+1)'(1);
    end else if (32'(image_width_i) > 32'(MAX_WIDTH)) begin
      width_eff = (AW+1)'(MAX_WIDTH);
    end else begin
      width_eff = (AW+1)'(image_width_i);
    end
    if (pix_i.start_of_frame) begin
      col   = '0;
      first = 1'b1;
    end else if ({1'b0, col_q} >= width_eff) begin
      col   = '0;
      first = 1'b0;
    end else begin
      col   = col_q;
      first = first_q;
    end
    col_next = {1'b0, col} + (AW+1)'(1);
  end

  always_comb begin
    job_o.cur     = cur_q;
    job_o.left    = left_q;
    job_o.upleft  = upleft_q;
    job_o.up      = up_rd_q;
    job_o.upright = upright_rd_q;
    job_o.present = present_q;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      up_rd_q       <= line_mem[col];
      upright_rd_q  <= line_mem[col_next[AW-1:0]];
      line_mem[col] <= cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      col_q     <= '0;
      first_q   <= 1'b1;
      left_q    <= '0;
      upleft_q  <= '0;
      cur_q     <= '0;
      present_q <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            cur_q                <= cur;
            present_q[NB_LEFT]    <= (col != '0);
            present_q[NB_UPLEFT]  <= (col != '0) && !first;
            present_q[NB_UP]      <= !first;
            present_q[NB_UPRIGHT] <= !first && (col_next < width_eff);
            if (col_next >= width_eff) begin
              col_q   <= '0;
              first_q <= 1'b0;
            end else begin
              col_q   <= col_next[AW-1:0];
              first_q <= first;
            end
            state_q <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (job_ready_i) begin
            left_q   <= cur_q;
            upleft_q <= up_rd_q;
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOK && !job_ready_i) |=> (state_q == ST_LOOK && $stable(cur_q)))
    else $error("pending job lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_o |-> (!present_q[NB_UPLEFT] || present_q[NB_LEFT]))
    else $error("upper-left neighbor without left neighbor");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_o |-> (!present_q[NB_UPRIGHT] || present_q[NB_UP]))
    else $error("upper-right neighbor on first line");

endmodule
`default_nettype wire

// ===== sv/nbw_weight.sv =====
// Pipelined unit that turns one color pair into one edge weight.
`default_nettype none
module nbw_weight #(
  parameter int unsigned EXP_TABLE_BITS = 10
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  nbw_pkg::wtag_t in_tag_i,
  input  logic [23:0]    cur_i,
  input  logic [23:0]    nb_i,
  input  logic [31:0]    beta_scale_i,
  input  logic [9:0]     gamma_weight_i,
  output logic           out_valid_o,
  output nbw_pkg::wtag_t out_tag_o,
  output logic [17:0]    weight_o
);
  import nbw_pkg::*;

  localparam int unsigned TSIZE = 1 << EXP_TABLE_BITS;

  typedef logic [30:0] rom_t [TSIZE];

  function automatic rom_t build_rom();
    rom_t        t;
    logic [63:0] r;
    r    = exp_root(EXP_TABLE_BITS);
    t[0] = 31'h4000_0000;
    for (int unsigned k = 1; k < TSIZE; k++) begin
      t[k] = 31'(((64'(t[k-1]) * r) + 64'h2000_0000) >> 30);
    end
    return t;
  endfunction

  localparam rom_t EXP_ROM = build_rom();

  logic [5:0]  valid_q;
  wtag_t       tag_q [6];
  logic [17:0] d2_q;
  logic [49:0] p_q;
  logic [21:0] y_q;
  logic [30:0] rom_q;
  logic [5:0]  n_q;
  logic [40:0] ge_q;
  logic [17:0] weight_q;

  logic [17:0] d2;
  logic [21:0] q;
  logic [52:0] y_full;
  logic [30:0] e_val;
  logic [40:0] axial_sum;
  logic [62:0] diag_sum;
  logic [8:0]  diff;
  logic [7:0]  mag;

  always_comb begin
    d2 = '0;
    for (int s = 0; s < 3; s++) begin
      diff = {1'b0, cur_i[8*s +: 8]} - {1'b0, nb_i[8*s +: 8]};
      mag  = diff[8] ? 8'(-diff) : diff[7:0];
      d2   = d2 + 18'(16'(mag) * 16'(mag));
    end
    q         = (p_q[49:16] > 34'(1 << 21)) ? 22'(1 << 21) : p_q[37:16];
    y_full    = 53'(q) * 53'(LOG2E_Q30);
    e_val     = (n_q >= 6'd31) ? '0 : (rom_q >> n_q);
    axial_sum = ge_q + 41'(1 << 21);
    diag_sum  = 63'(ge_q[40:8]) * 63'(INV_SQRT2_Q30) + (63'(1) << 43);
  end

  always_ff @(posedge clk_i) begin
    d2_q     <= d2;
    p_q      <= 50'(beta_scale_i) * 50'(d2_q);
    y_q      <= y_full[51:30];
    rom_q    <= EXP_ROM[y_q[15 -: EXP_TABLE_BITS]];
    n_q      <= y_q[21:16];
    ge_q     <= 41'(gamma_weight_i) * 41'(e_val);
    if (!tag_q[4].present) begin
      weight_q <= '0;
    end else if (tag_q[4].nb == NB_UPLEFT || tag_q[4].nb == NB_UPRIGHT) begin
      weight_q <= diag_sum[61:44];
    end else begin
      weight_q <= axial_sum[39:22];
    end
    tag_q[0] <= in_tag_i;
    for (int i = 1; i < 6; i++) begin
      tag_q[i] <= tag_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[4:0], in_valid_i};
    end
  end

  assign out_valid_o = valid_q[5];
  assign out_tag_o   = tag_q[5];
  assign weight_o    = weight_q;

endmodule
`default_nettype wire

// ===== sv/nbw_back.sv =====
// Back end: runs the four neighbors of a job through the weight unit and holds the result.
`default_nettype none
module nbw_back #(
  parameter int unsigned EXP_TABLE_BITS = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  input  nbw_pkg::job_t job_i,
  input  logic [31:0]   beta_scale_i,
  input  logic [9:0]    gamma_weight_i,
  output logic          wgt_valid_o,
  input  logic          wgt_ready_i,
  output nbw_pkg::wgt_t wgt_o
);
  import nbw_pkg::*;

  logic        busy_q;
  job_t        job_q;
  logic [2:0]  issue_cnt_q;
  logic [2:0]  got_cnt_q;
  logic [17:0] acc_q [4];
  logic        out_valid_q;
  wgt_t        out_q;

  logic        issue;
  wtag_t       issue_tag;
  logic [23:0] issue_nb;
  logic        res_valid;
  wtag_t       res_tag;
  logic [17:0] res_weight;
  logic        done;
  logic        out_free;

  assign job_ready_o = !busy_q;
  assign issue       = busy_q && (issue_cnt_q != 3'd4);
  assign done        = busy_q && (got_cnt_q == 3'd4);
  assign out_free    = !out_valid_q || wgt_ready_i;
  assign wgt_valid_o = out_valid_q;
  assign wgt_o       = out_q;

  always_comb begin
    issue_tag.nb      = nb_e'(issue_cnt_q[1:0]);
    issue_tag.present = job_q.present[issue_cnt_q[1:0]];
    case (issue_tag.nb)
      NB_LEFT:   issue_nb = job_q.left;
      NB_UPLEFT: issue_nb = job_q.upleft;
      NB_UP:     issue_nb = job_q.up;
      default:   issue_nb = job_q.upright;
    endcase
  end

  nbw_weight #(
    .EXP_TABLE_BITS(EXP_TABLE_BITS)
  ) u_weight (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (issue),
    .in_tag_i      (issue_tag),
    .cur_i         (job_q.cur),
    .nb_i          (issue_nb),
    .beta_scale_i  (beta_scale_i),
    .gamma_weight_i(gamma_weight_i),
    .out_valid_o   (res_valid),
    .out_tag_o     (res_tag),
    .weight_o      (res_weight)
  );

  always_ff @(posedge clk_i) begin
    if (job_valid_i && job_ready_o) begin
      job_q <= job_i;
    end
    if (res_valid) begin
      acc_q[res_tag.nb] <= res_weight;
    end
    if (done && out_free) begin
      out_q.left_weight    <= acc_q[NB_LEFT];
      out_q.upleft_weight  <= acc_q[NB_UPLEFT];
      out_q.up_weight      <= acc_q[NB_UP];
      out_q.upright_weight <= acc_q[NB_UPRIGHT];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      issue_cnt_q <= '0;
      got_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (job_valid_i && job_ready_o) begin
        busy_q      <= 1'b1;
        issue_cnt_q <= '0;
        got_cnt_q   <= '0;
      end else begin
        if (issue) begin
          issue_cnt_q <= issue_cnt_q + 3'd1;
        end
        if (res_valid) begin
          got_cnt_q <= got_cnt_q + 3'd1;
        end
        if (done && out_free) begin
          busy_q <= 1'b0;
        end
      end
      if (done && out_free) begin
        out_valid_q <= 1'b1;
      end else if (wgt_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) got_cnt_q <= issue_cnt_q)
    else $error("more weights returned than issued");
  assert property (@(posedge clk_i) disable iff (!rst_ni) issue_cnt_q <= 3'd4)
    else $error("issue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_valid |-> busy_q)
    else $error("weight returned with no job in progress");

endmodule
`default_nettype wire

// ===== sv/neighbor_edge_weight_stream.sv =====
// Top level of the neighbor edge weight stream with its configuration registers.
//
//   Channel  Direction  Handshake                Payload
//   pixel    in         pix_valid_i/pix_ready_o  pix_i (BGR, start of frame)
//   weight   out        wgt_valid_o/wgt_ready_i  wgt_o (four 18-bit weights)
//   config   in         cfg_we_i                 cfg_index_i, cfg_data_i
//
// The back end limits the pixel rate; it takes one job at a time and sends the four neighbors of
// each pixel one per cycle through a six-stage weight unit and then loads the output register.
// The front takes no new pixel until its job is taken, and a two-entry queue sits between.
// Reset does not clear the line store, which holds no valid bits.
// Either side may stall without losing a transaction.
`default_nettype none
module neighbor_edge_weight_stream #(
  parameter int unsigned MAX_WIDTH      = 2048,
  parameter int unsigned EXP_TABLE_BITS = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pix_valid_i,
  output logic          pix_ready_o,
  input  nbw_pkg::pix_t pix_i,
  output logic          wgt_valid_o,
  input  logic          wgt_ready_i,
  output nbw_pkg::wgt_t wgt_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i
);
  import nbw_pkg::*;

  logic [11:0] image_width_q;
  logic [31:0] beta_scale_q;
  logic [9:0]  gamma_weight_q;

  logic job_in_valid;
  logic job_in_ready;
  job_t job_in;
  logic job_out_valid;
  logic job_out_ready;
  job_t job_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= IMAGE_WIDTH_RST;
      beta_scale_q   <= BETA_SCALE_RST;
      gamma_weight_q <= GAMMA_WEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i[11:0];
        REG_BETA_SCALE:   beta_scale_q   <= cfg_data_i;
        REG_GAMMA_WEIGHT: gamma_weight_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  nbw_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_valid_i  (pix_valid_i),
    .pix_ready_o  (pix_ready_o),
    .pix_i        (pix_i),
    .image_width_i(image_width_q),
    .job_valid_o  (job_in_valid),
    .job_ready_i  (job_in_ready),
    .job_o        (job_in)
  );

  nbw_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(job_in_valid),
    .push_ready_o(job_in_ready),
    .push_i      (job_in),
    .pop_valid_o (job_out_valid),
    .pop_ready_i (job_out_ready),
    .pop_o       (job_out)
  );

  nbw_back #(
    .EXP_TABLE_BITS(EXP_TABLE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (job_out_valid),
    .job_ready_o   (job_out_ready),
    .job_i         (job_out),
    .beta_scale_i  (beta_scale_q),
    .gamma_weight_i(gamma_weight_q),
    .wgt_valid_o   (wgt_valid_o),
    .wgt_ready_i   (wgt_ready_i),
    .wgt_o         (wgt_o)
  );

endmodule
`default_nettype wire
